// ===== hdl/load_frame_parser_word_packer_core_assert.svh =====
// assertion macros used by the core rtl file
// no dependencies; included by the top level
`ifndef LOAD_FRAME_PARSER_WORD_PACKER_CORE_ASSERT_SVH
`define LOAD_FRAME_PARSER_WORD_PACKER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lfp_pkg.sv =====
// types, constants and helpers for the frame parser and word packer
// no dependencies; used by the core, front, queue and back rtl files
`default_nettype none
package lfp_pkg;

    localparam int ADDR_BITS   = 20;
    localparam int LENGTH_BITS = 32;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CFG_ADDR_W  = 3;

    localparam logic CFG_IDX_MAX_NAME_LEN = 1'b0;
    localparam logic [4:0] MAX_NAME_RESET = 5'd12;

    localparam logic [7:0] CH_COLON   = 8'h3a;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7a;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    typedef enum logic [2:0] {
        PH_CMD  = 3'd0,
        PH_SEP  = 3'd1,
        PH_LEN  = 3'd2,
        PH_NAME = 3'd3,
        PH_DATA = 3'd4,
        PH_DONE = 3'd5,
        PH_ERR  = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        EV_NAME   = 3'd0,
        EV_HDR    = 3'd1,
        EV_WORD   = 3'd2,
        EV_FBYTE  = 3'd3,
        EV_DONE   = 3'd4,
        EV_BADCMD = 3'd5,
        EV_LONG   = 3'd6
    } t_event;

    typedef struct packed {
        t_event      event_res;
        logic [31:0] word_value;
        logic [19:0] word_index;
        logic [7:0]  char_value;
        logic [31:0] length_value;
        logic        to_file;
        logic        last;
    } t_result;

    // one queue entry: the first result of a byte, optionally followed by done
    typedef struct packed {
        t_result first;
        logic    add_done;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // command letters: EXEC for program load, DOWN for file download
    function automatic logic [7:0] cmd_char(input logic to_file, input logic [1:0] pos);
        logic [7:0] c;
        if (to_file) begin
            unique case (pos)
                2'd0: c = 8'h44;
                2'd1: c = 8'h4f;
                2'd2: c = 8'h57;
                2'd3: c = 8'h4e;
                default: c = 8'h00;
            endcase
        end else begin
            unique case (pos)
                2'd0: c = 8'h45;
                2'd1: c = 8'h58;
                2'd2: c = 8'h45;
                2'd3: c = 8'h43;
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b >= CH_LOW_A && b <= CH_LOW_Z) begin
            c = b - CASE_DIFF;
        end
        return c;
    endfunction

    function automatic t_result done_result(input logic to_file);
        t_result r;
        r = '0;
        r.event_res = EV_DONE;
        r.to_file   = to_file;
        r.last      = 1'b1;
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lfp_if.sv =====
// byte input and result output channel interfaces
// depends on lfp_pkg for nothing but kept after it in compile order
`default_nettype none
interface lfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       session_start;

    modport source (output valid, output byte_value, output session_start, input ready);
    modport sink (input valid, input byte_value, input session_start, output ready);
endinterface

interface lfp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [31:0] word_value;
    logic [19:0] word_index;
    logic [7:0]  char_value;
    logic [31:0] length_value;
    logic        to_file;
    logic        last;

    modport source (output valid, output event_res, output word_value, output word_index,
                    output char_value, output length_value, output to_file, output last,
                    input ready);
    modport sink (input valid, input event_res, input word_value, input word_index,
                  input char_value, input length_value, input to_file, input last,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/load_frame_parser_word_packer_core.sv =====
// an accepted byte's result is written into the queue, then registered at the output
// throughput: one byte per cycle while the queue is not full; a byte that ends the
// frame yields two results, and the four-entry queue absorbs the difference
// input is held off only while the queue is full
// reset: synchronous active-low; parser returns to command match, name limit to 12
`default_nettype none
`include "load_frame_parser_word_packer_core_assert.svh"
module load_frame_parser_word_packer_core
    import lfp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    lfp_in_if.sink                     i_in,
    lfp_out_if.source                  o_out,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic      [4:0] r_max_name_len;
    logic      cfg_wr;
    logic      in_accept;
    logic      push;
    logic      pop;
    t_entry    push_entry;
    t_entry    head_entry;
    t_q_status q_status;
    t_result   out_res;
    logic      out_valid;

    // register file: one register, decoded from address bit 2 alone, so it answers at addresses zero to three
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CFG_IDX_MAX_NAME_LEN) ? 32'(r_max_name_len) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_name_len <= MAX_NAME_RESET;
        end else if (cfg_wr && paddr[2] == CFG_IDX_MAX_NAME_LEN) begin
            r_max_name_len <= pwdata[4:0];
        end
    end

    assign i_in.ready = !q_status.full;
    assign in_accept  = i_in.valid && i_in.ready;

    lfp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_byte         (i_in.byte_value),
        .i_start        (i_in.session_start),
        .i_max_name_len (r_max_name_len),
        .o_push         (push),
        .o_entry        (push_entry)
    );

    lfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_entry  (head_entry),
        .o_status (q_status)
    );

    lfp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head_entry),
        .i_status (q_status),
        .o_pop    (pop),
        .o_valid  (out_valid),
        .i_ready  (o_out.ready),
        .o_res    (out_res)
    );

    assign o_out.valid        = out_valid;
    assign o_out.event_res    = out_res.event_res;
    assign o_out.word_value   = out_res.word_value;
    assign o_out.word_index   = out_res.word_index;
    assign o_out.char_value   = out_res.char_value;
    assign o_out.length_value = out_res.length_value;
    assign o_out.to_file      = out_res.to_file;
    assign o_out.last         = out_res.last;

    `LFP_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, push, !q_status.full,
        "entry pushed into a full queue")
    `LFP_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, pop, !q_status.empty,
        "entry popped from an empty queue")
    `LFP_ASSERT_IMPLY(a_final_last, i_clk, i_rst_n,
        out_valid && (out_res.event_res == EV_DONE || out_res.event_res == EV_BADCMD ||
        out_res.event_res == EV_LONG), out_res.last,
        "terminating result without last")
    `LFP_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n,
        out_valid && !out_res.last && o_out.ready,
        out_valid && out_res.event_res == EV_DONE,
        "result without last not followed by done")

endmodule
`default_nettype wire

// ===== hdl/lfp_front.sv =====
// front end: frame parser, length counter and big-endian word packer
// depends on lfp_pkg; pushes one entry per byte that has results
`default_nettype none
module lfp_front
    import lfp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_start,
    input  wire logic [4:0] i_max_name_len,
    output logic            o_push,
    output t_entry          o_entry
);

    t_phase                 r_phase, n_phase;
    logic [1:0]             r_pos, n_pos;
    logic                   r_mode, n_mode;
    logic [LENGTH_BITS-1:0] r_rem, n_rem;
    logic [1:0]             r_lane, n_lane;
    logic [31:0]            r_acc, n_acc;
    logic [ADDR_BITS-1:0]   r_widx, n_widx;
    logic [4:0]             r_ncnt, n_ncnt;

    t_phase                 b_phase;
    logic [1:0]             b_pos;
    logic                   b_mode;
    logic [LENGTH_BITS-1:0] b_rem;
    logic [1:0]             b_lane;
    logic [31:0]            b_acc;
    logic [ADDR_BITS-1:0]   b_widx;
    logic [4:0]             b_ncnt;

    logic                   has_res;
    logic                   add_done;
    t_event                 ev;
    logic [31:0]            wv;
    logic [19:0]            wi;
    logic [7:0]             ch;
    logic [31:0]            lv;
    logic                   cmd_ok;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [31:0]            lane_acc;
    logic [7:0]             digit;

    always_comb begin
        // session start clears the parser before this byte is parsed
        if (i_start) begin
            b_phase = PH_CMD;
            b_pos   = '0;
            b_mode  = 1'b0;
            b_rem   = '0;
            b_lane  = '0;
            b_acc   = '0;
            b_widx  = '0;
            b_ncnt  = '0;
        end else begin
            b_phase = r_phase;
            b_pos   = r_pos;
            b_mode  = r_mode;
            b_rem   = r_rem;
            b_lane  = r_lane;
            b_acc   = r_acc;
            b_widx  = r_widx;
            b_ncnt  = r_ncnt;
        end

        n_phase = b_phase;
        n_pos   = b_pos;
        n_mode  = b_mode;
        n_rem   = b_rem;
        n_lane  = b_lane;
        n_acc   = b_acc;
        n_widx  = b_widx;
        n_ncnt  = b_ncnt;

        has_res  = 1'b0;
        add_done = 1'b0;
        ev       = EV_NAME;
        wv       = '0;
        wi       = '0;
        ch       = '0;
        lv       = '0;
        cmd_ok   = 1'b0;
        rem_dec  = b_rem - LENGTH_BITS'(1);
        lane_acc = b_acc | (32'(i_byte) << (5'd24 - {b_lane, 3'b000}));
        digit    = i_byte - CH_ZERO;

        unique case (b_phase)
            PH_CMD: begin
                if (b_pos == 2'd0) begin
                    if (i_byte == cmd_char(1'b0, 2'd0)) begin
                        n_mode = 1'b0;
                        cmd_ok = 1'b1;
                    end else if (i_byte == cmd_char(1'b1, 2'd0)) begin
                        n_mode = 1'b1;
                        cmd_ok = 1'b1;
                    end
                end else begin
                    cmd_ok = (i_byte == cmd_char(b_mode, b_pos));
                end
                if (!cmd_ok) begin
                    has_res = 1'b1;
                    ev      = EV_BADCMD;
                    n_phase = PH_ERR;
                end else if (b_pos == 2'd3) begin
                    n_phase = PH_SEP;
                end else begin
                    n_pos = b_pos + 2'd1;
                end
            end
            PH_SEP: begin
                n_phase = PH_LEN;
            end
            PH_LEN: begin
                if (i_byte == CH_COLON) begin
                    n_phase = PH_NAME;
                end else if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
                    // times ten as two shifts and an add
                    n_rem = (b_rem << 3) + (b_rem << 1) + LENGTH_BITS'(digit);
                end else begin
                    has_res = 1'b1;
                    ev      = EV_BADCMD;
                    n_phase = PH_ERR;
                end
            end
            PH_NAME: begin
                if (i_byte == CH_NEWLINE) begin
                    has_res = 1'b1;
                    ev      = EV_HDR;
                    lv      = 32'(b_rem);
                    if (b_rem == '0) begin
                        add_done = 1'b1;
                        n_phase  = PH_DONE;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else if (b_mode) begin
                    has_res = 1'b1;
                    if (b_ncnt >= i_max_name_len) begin
                        ev      = EV_LONG;
                        n_phase = PH_ERR;
                    end else begin
                        ev     = EV_NAME;
                        ch     = to_upper(i_byte);
                        n_ncnt = b_ncnt + 5'd1;
                    end
                end
            end
            PH_DATA: begin
                n_rem = rem_dec;
                if (b_mode) begin
                    has_res = 1'b1;
                    ev      = EV_FBYTE;
                    ch      = i_byte;
                end else begin
                    n_acc = lane_acc;
                    // full word, or the last byte flushes a partial one
                    if (b_lane == 2'd3 || rem_dec == '0) begin
                        has_res = 1'b1;
                        ev      = EV_WORD;
                        wv      = lane_acc;
                        wi      = 20'(b_widx);
                        n_widx  = b_widx + ADDR_BITS'(1);
                        n_acc   = '0;
                        n_lane  = '0;
                    end else begin
                        n_lane = b_lane + 2'd1;
                    end
                end
                if (rem_dec == '0) begin
                    add_done = 1'b1;
                    n_phase  = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        o_push                 = i_accept && has_res;
        o_entry.add_done       = add_done;
        o_entry.first.event_res    = ev;
        o_entry.first.word_value   = wv;
        o_entry.first.word_index   = wi;
        o_entry.first.char_value   = ch;
        o_entry.first.length_value = lv;
        o_entry.first.to_file      = n_mode;
        o_entry.first.last         = !add_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_pos   <= '0;
            r_mode  <= 1'b0;
            r_rem   <= '0;
            r_lane  <= '0;
            r_acc   <= '0;
            r_widx  <= '0;
            r_ncnt  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_mode  <= n_mode;
            r_rem   <= n_rem;
            r_lane  <= n_lane;
            r_acc   <= n_acc;
            r_widx  <= n_widx;
            r_ncnt  <= n_ncnt;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lfp_queue.sv =====
// small register queue between the parser and the result serializer
// depends on lfp_pkg for the entry type and depth
`default_nettype none
module lfp_queue
    import lfp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output t_entry      o_entry,
    output t_q_status   o_status
);

    t_entry             r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_wptr = i_push ? r_wptr + QPTR_W'(1) : r_wptr;
        n_rptr = i_pop ? r_rptr + QPTR_W'(1) : r_rptr;
        n_cnt  = r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        o_status.full  = (r_cnt == QCNT_W'(QDEPTH));
        o_status.empty = (r_cnt == '0);
        o_entry        = r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lfp_back.sv =====
// back end: splits queue entries into single results in an output register
// depends on lfp_pkg; drives the result channel
`default_nettype none
module lfp_back
    import lfp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_entry    i_entry,
    input  wire t_q_status i_status,
    output logic           o_pop,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_result        o_res
);

    logic    r_valid, n_valid;
    logic    r_pend, n_pend;
    t_result r_res, n_res;
    logic    out_free;

    always_comb begin
        out_free = !r_valid || i_ready;
        n_valid  = r_valid;
        n_pend   = r_pend;
        n_res    = r_res;
        o_pop    = 1'b0;
        if (out_free) begin
            priority if (r_pend) begin
                // trailing done for the byte just shown
                n_res   = done_result(r_res.to_file);
                n_pend  = 1'b0;
                n_valid = 1'b1;
            end else if (!i_status.empty) begin
                o_pop   = 1'b1;
                n_res   = i_entry.first;
                n_pend  = i_entry.add_done;
                n_valid = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
        o_valid = r_valid;
        o_res   = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule
`default_nettype wire
